/* sv/circumcircle_from_three_points_unit_macros.svh */
// Assertion macros for the circumcircle unit.
// Used by the top level only; no other dependencies.
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_UNIT_MACROS_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CCP_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("circumcircle unit: same-cycle check failed");
`define CCP_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("circumcircle unit: next-cycle check failed");
`else
`define CCP_ASSERT_IMP(label, ck, rn, ante, cons)
`define CCP_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

/* sv/ccp_pkg.sv */
// Shared types and constants for the circumcircle unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ccp_pkg;

    localparam int COORD_W = 16;
    localparam int OUT_W   = 48;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_VERT = 2'd1;
    localparam logic [1:0] STAT_HORZ = 2'd2;
    localparam logic [1:0] STAT_COLL = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } pts_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic        [OUT_W-1:0] radius;
        logic        [1:0]       status;
    } circ_t;

endpackage

/* sv/ccp_div.sv */
// Pipelined restoring divider: two numerators over one shared divisor, one
// quotient bit per stage, then a round-to-nearest stage. Uses ccp_pkg.
`timescale 1ns / 1ps
module ccp_div #(
    parameter int NUM_W = 67,
    parameter int DEN_W = 35,
    parameter int TAG_W = 36
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             num_valid,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag,
    output logic             quo_valid,
    output logic [NUM_W-1:0] quo_x,
    output logic [NUM_W-1:0] quo_y,
    output logic [TAG_W-1:0] quo_tag
);
    import ccp_pkg::*;

    // One step: shift the next numerator bit into the remainder and the
    // quotient bit into the freed low end of the numerator word.
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [NUM_W-1:0] q,
        input logic [DEN_W-1:0] dm
    );
        logic [DEN_W:0] sh;
        logic           ge;
        sh = {rem, q[NUM_W-1]};
        ge = (sh >= {1'b0, dm});
        if (ge)
        begin
            sh = sh - {1'b0, dm};
        end
        return {sh[DEN_W-1:0], q[NUM_W-2:0], ge};
    endfunction

    logic             vld_reg [NUM_W];
    logic [NUM_W-1:0] qx_reg  [NUM_W];
    logic [NUM_W-1:0] qy_reg  [NUM_W];
    logic [DEN_W-1:0] rx_reg  [NUM_W];
    logic [DEN_W-1:0] ry_reg  [NUM_W];
    logic [DEN_W-1:0] dm_reg  [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        logic             v_cur;
        logic [NUM_W-1:0] qx_cur;
        logic [NUM_W-1:0] qy_cur;
        logic [DEN_W-1:0] rx_cur;
        logic [DEN_W-1:0] ry_cur;
        logic [DEN_W-1:0] dm_cur;
        logic [TAG_W-1:0] tag_cur;

        if (k == 0)
        begin : g_first
            assign v_cur   = num_valid;
            assign qx_cur  = num_x;
            assign qy_cur  = num_y;
            assign rx_cur  = '0;
            assign ry_cur  = '0;
            assign dm_cur  = den;
            assign tag_cur = tag;
        end
        else
        begin : g_next
            assign v_cur   = vld_reg[k-1];
            assign qx_cur  = qx_reg[k-1];
            assign qy_cur  = qy_reg[k-1];
            assign rx_cur  = rx_reg[k-1];
            assign ry_cur  = ry_reg[k-1];
            assign dm_cur  = dm_reg[k-1];
            assign tag_cur = tag_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {rx_reg[k], qx_reg[k]} <= div_step(rx_cur, qx_cur, dm_cur);
                {ry_reg[k], qy_reg[k]} <= div_step(ry_cur, qy_cur, dm_cur);
                dm_reg[k]  <= dm_cur;
                tag_reg[k] <= tag_cur;
            end
        end
    end

    localparam int LAST = NUM_W - 1;

    logic             rnd_x;
    logic             rnd_y;
    logic             out_vld_reg;
    logic [NUM_W-1:0] out_qx_reg;
    logic [NUM_W-1:0] out_qy_reg;
    logic [TAG_W-1:0] out_tag_reg;

    // Round half away from zero: bump when the remainder is at least half
    // the divisor. The remainder is always below the divisor here.
    assign rnd_x = (rx_reg[LAST] >= (dm_reg[LAST] - rx_reg[LAST]));
    assign rnd_y = (ry_reg[LAST] >= (dm_reg[LAST] - ry_reg[LAST]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_qx_reg  <= qx_reg[LAST] + {{(NUM_W-1){1'b0}}, rnd_x};
            out_qy_reg  <= qy_reg[LAST] + {{(NUM_W-1){1'b0}}, rnd_y};
            out_tag_reg <= tag_reg[LAST];
        end
    end

    assign quo_valid = out_vld_reg;
    assign quo_x     = out_qx_reg;
    assign quo_y     = out_qy_reg;
    assign quo_tag   = out_tag_reg;

endmodule

/* sv/ccp_sqrt.sv */
// Pipelined radius unit: squares the two offsets from half-width partial
// products, sums them and takes a rounded restoring square root. Uses ccp_pkg.
`timescale 1ns / 1ps
module ccp_sqrt #(
    parameter int TAG_W = 98
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      op_valid,
    input  logic [ccp_pkg::OUT_W-1:0] ox,
    input  logic [ccp_pkg::OUT_W-1:0] oy,
    input  logic                      sat,
    input  logic [TAG_W-1:0]          tag,
    output logic                      root_valid,
    output logic [ccp_pkg::OUT_W-1:0] radius,
    output logic [TAG_W-1:0]          root_tag
);
    import ccp_pkg::*;

    localparam int HW  = OUT_W / 2;
    localparam int SW  = OUT_W + 1;
    localparam int NW2 = 2 * SW;
    localparam int SQW = 2 * OUT_W;

    // One root bit per step; n is consumed two bits at a time from the top.
    function automatic logic [(SW+1)+SW+NW2-1:0] sq_step(
        input logic [SW:0]    r,
        input logic [SW-1:0]  s,
        input logic [NW2-1:0] n
    );
        logic [SW+2:0] rp;
        logic [SW+2:0] tr;
        logic          ge;
        rp = {r, n[NW2-1:NW2-2]};
        tr = {1'b0, s, 2'b01};
        ge = (rp >= tr);
        if (ge)
        begin
            rp = rp - tr;
        end
        return {rp[SW:0], s[SW-2:0], ge, n[NW2-3:0], 2'b00};
    endfunction

    // Partial products
    logic             vm_reg;
    logic [OUT_W-1:0] hhx_reg, hlx_reg, llx_reg;
    logic [OUT_W-1:0] hhy_reg, hly_reg, lly_reg;
    logic             satm_reg;
    logic [TAG_W-1:0] tagm_reg;
    // Squares
    logic             vs_reg;
    logic [SQW-1:0]   sqx_reg, sqy_reg;
    logic             sats_reg;
    logic [TAG_W-1:0] tags_reg;
    // Sum of squares
    logic             vn_reg;
    logic [NW2-1:0]   n_reg;
    logic             satn_reg;
    logic [TAG_W-1:0] tagn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vs_reg <= 1'b0;
            vn_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= op_valid;
            vs_reg <= vm_reg;
            vn_reg <= vs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hhx_reg  <= ox[OUT_W-1:HW] * ox[OUT_W-1:HW];
            hlx_reg  <= ox[OUT_W-1:HW] * ox[HW-1:0];
            llx_reg  <= ox[HW-1:0] * ox[HW-1:0];
            hhy_reg  <= oy[OUT_W-1:HW] * oy[OUT_W-1:HW];
            hly_reg  <= oy[OUT_W-1:HW] * oy[HW-1:0];
            lly_reg  <= oy[HW-1:0] * oy[HW-1:0];
            satm_reg <= sat;
            tagm_reg <= tag;

            // The cross term appears twice, hence the extra bit of shift.
            sqx_reg  <= {hhx_reg, llx_reg} + (SQW'(hlx_reg) << (HW + 1));
            sqy_reg  <= {hhy_reg, lly_reg} + (SQW'(hly_reg) << (HW + 1));
            sats_reg <= satm_reg;
            tags_reg <= tagm_reg;

            n_reg    <= NW2'(sqx_reg) + NW2'(sqy_reg);
            satn_reg <= sats_reg;
            tagn_reg <= tags_reg;
        end
    end

    logic             vr_reg   [SW];
    logic [SW:0]      r_reg    [SW];
    logic [SW-1:0]    s_reg    [SW];
    logic [NW2-1:0]   nsh_reg  [SW];
    logic             satr_reg [SW];
    logic [TAG_W-1:0] tagr_reg [SW];

    for (genvar k = 0; k < SW; k++)
    begin : g_root
        logic             v_cur;
        logic [SW:0]      r_cur;
        logic [SW-1:0]    s_cur;
        logic [NW2-1:0]   n_cur;
        logic             sat_cur;
        logic [TAG_W-1:0] tag_cur;

        if (k == 0)
        begin : g_first
            assign v_cur   = vn_reg;
            assign r_cur   = '0;
            assign s_cur   = '0;
            assign n_cur   = n_reg;
            assign sat_cur = satn_reg;
            assign tag_cur = tagn_reg;
        end
        else
        begin : g_next
            assign v_cur   = vr_reg[k-1];
            assign r_cur   = r_reg[k-1];
            assign s_cur   = s_reg[k-1];
            assign n_cur   = nsh_reg[k-1];
            assign sat_cur = satr_reg[k-1];
            assign tag_cur = tagr_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vr_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vr_reg[k] <= v_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {r_reg[k], s_reg[k], nsh_reg[k]} <= sq_step(r_cur, s_cur, n_cur);
                satr_reg[k] <= sat_cur;
                tagr_reg[k] <= tag_cur;
            end
        end
    end

    localparam int LAST = SW - 1;

    logic [SW:0]      s_rnd;
    logic             out_vld_reg;
    logic [OUT_W-1:0] out_rad_reg;
    logic [TAG_W-1:0] out_tag_reg;

    // n > s*s + s exactly when the remainder exceeds s.
    assign s_rnd = {1'b0, s_reg[LAST]}
                 + {{SW{1'b0}}, (r_reg[LAST] > {1'b0, s_reg[LAST]})};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vr_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (satr_reg[LAST] || (|s_rnd[SW:OUT_W]))
            begin
                out_rad_reg <= '1;
            end
            else
            begin
                out_rad_reg <= s_rnd[OUT_W-1:0];
            end
            out_tag_reg <= tagr_reg[LAST];
        end
    end

    assign root_valid = out_vld_reg;
    assign radius     = out_rad_reg;
    assign root_tag   = out_tag_reg;

endmodule

/* sv/circumcircle_from_three_points_unit.sv */
// Circumcircle unit: center and radius of the circle through three points.
// The divider and square-root pipelines each resolve one result bit per stage.
// Throughput: one word per cycle; a held result stalls the whole pipeline.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// Depends on ccp_pkg, ccp_div, ccp_sqrt and the assertion macro header.
`timescale 1ns / 1ps
`include "circumcircle_from_three_points_unit_macros.svh"
module circumcircle_from_three_points_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pts_valid,
    output logic           pts_stall,
    input  ccp_pkg::pts_t  pts,
    output logic           circ_valid,
    input  logic           circ_stall,
    output ccp_pkg::circ_t circ
);
    import ccp_pkg::*;

    localparam int W      = COORD_W;
    localparam int DW     = W + 1;
    localparam int PW     = 2 * DW;
    localparam int DSW    = 2 * DW + 2;
    localparam int DMW    = 2 * W + 3;
    localparam int SQW    = 2 * W + 2;
    localparam int MW     = 3 * W + 4;
    localparam int NXW    = MW + 1;
    localparam int NMW    = 3 * W + 3;
    localparam int QW     = NMW + FRAC_BITS;
    localparam int SUMW   = QW + 2;
    localparam int TAGD_W = 4 + 2 * W;
    localparam int TAGS_W = 2 + 2 * OUT_W;

    logic en;

    // The pipeline advances whenever the output register can take a word.
    assign en        = !circ_valid || !circ_stall;
    assign pts_stall = !en;

    // Stage 1: chord vectors and the vertical and horizontal checks.
    logic                v1_reg;
    logic signed [W-1:0] ax1_reg, ay1_reg;
    logic signed [DW-1:0] dbx1_reg, dby1_reg, dcx1_reg, dcy1_reg;
    logic                vert1_reg, horz1_reg;
    // Stage 2: products.
    logic                v2_reg;
    logic signed [W-1:0] ax2_reg, ay2_reg;
    logic signed [DW-1:0] dbx2_reg, dby2_reg, dcx2_reg, dcy2_reg;
    logic signed [PW-1:0] pbc2_reg, pcb2_reg;
    logic [PW-1:0]       qbx2_reg, qby2_reg, qcx2_reg, qcy2_reg;
    logic                vert2_reg, horz2_reg;
    // Stage 3: determinant, squared chord lengths, status.
    logic                v3_reg;
    logic signed [W-1:0] ax3_reg, ay3_reg;
    logic signed [DW-1:0] dbx3_reg, dby3_reg, dcx3_reg, dcy3_reg;
    logic signed [DSW-1:0] d3_reg;
    logic [SQW-1:0]      sb3_reg, sc3_reg;
    logic [1:0]          st3_reg;
    // Stage 4: numerator products.
    logic                v4_reg;
    logic signed [W-1:0] ax4_reg, ay4_reg;
    logic signed [DSW-1:0] d4_reg;
    logic signed [MW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    logic [1:0]          st4_reg;
    // Stage 5: numerators.
    logic                v5_reg;
    logic signed [W-1:0] ax5_reg, ay5_reg;
    logic signed [DSW-1:0] d5_reg;
    logic signed [NXW-1:0] nx5_reg, ny5_reg;
    logic [1:0]          st5_reg;
    // Stage 6: magnitudes and quotient signs for the divider.
    logic                v6_reg;
    logic signed [W-1:0] ax6_reg, ay6_reg;
    logic [NMW-1:0]      nmx6_reg, nmy6_reg;
    logic [DMW-1:0]      dm6_reg;
    logic                nsx6_reg, nsy6_reg;
    logic [1:0]          st6_reg;

    logic [1:0]          st3_next;
    logic [NXW-1:0]      absx, absy;
    logic [DSW-1:0]      absd;

    always_comb
    begin
        if (vert2_reg)
        begin
            st3_next = STAT_VERT;
        end
        else if (horz2_reg)
        begin
            st3_next = STAT_HORZ;
        end
        else if (pbc2_reg == pcb2_reg)
        begin
            st3_next = STAT_COLL;
        end
        else
        begin
            st3_next = STAT_OK;
        end
    end

    assign absx = nx5_reg[NXW-1] ? (-nx5_reg) : nx5_reg;
    assign absy = ny5_reg[NXW-1] ? (-ny5_reg) : ny5_reg;
    assign absd = d5_reg[DSW-1] ? (-d5_reg) : d5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pts_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= pts.ax;
            ay1_reg   <= pts.ay;
            dbx1_reg  <= {pts.bx[W-1], pts.bx} - {pts.ax[W-1], pts.ax};
            dby1_reg  <= {pts.by_coord[W-1], pts.by_coord} - {pts.ay[W-1], pts.ay};
            dcx1_reg  <= {pts.cx[W-1], pts.cx} - {pts.ax[W-1], pts.ax};
            dcy1_reg  <= {pts.cy[W-1], pts.cy} - {pts.ay[W-1], pts.ay};
            vert1_reg <= (pts.ax == pts.bx) || (pts.ax == pts.cx);
            horz1_reg <= (pts.ay == pts.by_coord) || (pts.ay == pts.cy);

            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            dbx2_reg  <= dbx1_reg;
            dby2_reg  <= dby1_reg;
            dcx2_reg  <= dcx1_reg;
            dcy2_reg  <= dcy1_reg;
            pbc2_reg  <= dbx1_reg * dcy1_reg;
            pcb2_reg  <= dby1_reg * dcx1_reg;
            qbx2_reg  <= dbx1_reg * dbx1_reg;
            qby2_reg  <= dby1_reg * dby1_reg;
            qcx2_reg  <= dcx1_reg * dcx1_reg;
            qcy2_reg  <= dcy1_reg * dcy1_reg;
            vert2_reg <= vert1_reg;
            horz2_reg <= horz1_reg;

            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            dbx3_reg  <= dbx2_reg;
            dby3_reg  <= dby2_reg;
            dcx3_reg  <= dcx2_reg;
            dcy3_reg  <= dcy2_reg;
            d3_reg    <= {({pbc2_reg[PW-1], pbc2_reg} - {pcb2_reg[PW-1], pcb2_reg}), 1'b0};
            sb3_reg   <= qbx2_reg + qby2_reg;
            sc3_reg   <= qcx2_reg + qcy2_reg;
            st3_reg   <= st3_next;

            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            d4_reg    <= d3_reg;
            m1_reg    <= dcy3_reg * $signed({1'b0, sb3_reg});
            m2_reg    <= dby3_reg * $signed({1'b0, sc3_reg});
            m3_reg    <= dbx3_reg * $signed({1'b0, sc3_reg});
            m4_reg    <= dcx3_reg * $signed({1'b0, sb3_reg});
            st4_reg   <= st3_reg;

            ax5_reg   <= ax4_reg;
            ay5_reg   <= ay4_reg;
            d5_reg    <= d4_reg;
            nx5_reg   <= {m1_reg[MW-1], m1_reg} - {m2_reg[MW-1], m2_reg};
            ny5_reg   <= {m3_reg[MW-1], m3_reg} - {m4_reg[MW-1], m4_reg};
            st5_reg   <= st4_reg;

            ax6_reg   <= ax5_reg;
            ay6_reg   <= ay5_reg;
            nmx6_reg  <= absx[NMW-1:0];
            nmy6_reg  <= absy[NMW-1:0];
            dm6_reg   <= absd[DMW-1:0];
            nsx6_reg  <= nx5_reg[NXW-1] ^ d5_reg[DSW-1];
            nsy6_reg  <= ny5_reg[NXW-1] ^ d5_reg[DSW-1];
            st6_reg   <= st5_reg;
        end
    end

    logic              dq_valid;
    logic [QW-1:0]     dq_x, dq_y;
    logic [TAGD_W-1:0] dq_tag;

    ccp_div #(
        .NUM_W (QW),
        .DEN_W (DMW),
        .TAG_W (TAGD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .num_valid (v6_reg),
        .num_x     ({nmx6_reg, {FRAC_BITS{1'b0}}}),
        .num_y     ({nmy6_reg, {FRAC_BITS{1'b0}}}),
        .den       (dm6_reg),
        .tag       ({st6_reg, nsx6_reg, nsy6_reg, ax6_reg, ay6_reg}),
        .quo_valid (dq_valid),
        .quo_x     (dq_x),
        .quo_y     (dq_y),
        .quo_tag   (dq_tag)
    );

    // Stage 7: center = A + signed offset, saturated to the output width.
    logic [1:0]            dq_st;
    logic                  dq_nsx, dq_nsy;
    logic signed [W-1:0]   dq_ax, dq_ay;
    logic signed [SUMW-1:0] offx, offy, basex, basey, sumx, sumy;
    logic [OUT_W-1:0]      cx_next, cy_next;
    logic                  fitx, fity;

    assign {dq_st, dq_nsx, dq_nsy, dq_ax, dq_ay} = dq_tag;

    assign offx  = dq_nsx ? (-$signed({2'b00, dq_x})) : $signed({2'b00, dq_x});
    assign offy  = dq_nsy ? (-$signed({2'b00, dq_y})) : $signed({2'b00, dq_y});
    assign basex = SUMW'(dq_ax) <<< FRAC_BITS;
    assign basey = SUMW'(dq_ay) <<< FRAC_BITS;
    assign sumx  = basex + offx;
    assign sumy  = basey + offy;
    assign fitx  = (&sumx[SUMW-1:OUT_W-1]) || !(|sumx[SUMW-1:OUT_W-1]);
    assign fity  = (&sumy[SUMW-1:OUT_W-1]) || !(|sumy[SUMW-1:OUT_W-1]);

    always_comb
    begin
        if (fitx)
        begin
            cx_next = sumx[OUT_W-1:0];
        end
        else
        begin
            cx_next = sumx[SUMW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        if (fity)
        begin
            cy_next = sumy[OUT_W-1:0];
        end
        else
        begin
            cy_next = sumy[SUMW-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    logic             v7_reg;
    logic [OUT_W-1:0] ox7_reg, oy7_reg;
    logic             rsat7_reg;
    logic [OUT_W-1:0] cx7_reg, cy7_reg;
    logic [1:0]       st7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= dq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox7_reg   <= dq_x[OUT_W-1:0];
            oy7_reg   <= dq_y[OUT_W-1:0];
            rsat7_reg <= (|dq_x[QW-1:OUT_W]) || (|dq_y[QW-1:OUT_W]);
            cx7_reg   <= cx_next;
            cy7_reg   <= cy_next;
            st7_reg   <= dq_st;
        end
    end

    logic              rt_valid;
    logic [OUT_W-1:0]  rt_radius;
    logic [TAGS_W-1:0] rt_tag;

    ccp_sqrt #(
        .TAG_W (TAGS_W)
    ) u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .op_valid   (v7_reg),
        .ox         (ox7_reg),
        .oy         (oy7_reg),
        .sat        (rsat7_reg),
        .tag        ({st7_reg, cx7_reg, cy7_reg}),
        .root_valid (rt_valid),
        .radius     (rt_radius),
        .root_tag   (rt_tag)
    );

    // Output register; a failed triangle reports zeros beside its status.
    logic [1:0]       rt_st;
    logic [OUT_W-1:0] rt_cx, rt_cy;
    logic             circ_valid_reg;
    circ_t            circ_reg;

    assign {rt_st, rt_cx, rt_cy} = rt_tag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            circ_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            circ_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            circ_reg.status <= rt_st;
            if (rt_st == STAT_OK)
            begin
                circ_reg.center_x <= rt_cx;
                circ_reg.center_y <= rt_cy;
                circ_reg.radius   <= rt_radius;
            end
            else
            begin
                circ_reg.center_x <= '0;
                circ_reg.center_y <= '0;
                circ_reg.radius   <= '0;
            end
        end
    end

    assign circ_valid = circ_valid_reg;
    assign circ       = circ_reg;

`CCP_ASSERT_IMP(a_fail_zero, clk, rst_n, circ_valid && circ.status != STAT_OK, circ.center_x == '0 && circ.center_y == '0 && circ.radius == '0)
`CCP_ASSERT_IMP(a_stall_cause, clk, rst_n, pts_stall, circ_valid && circ_stall)
`CCP_ASSERT_IMP(a_ok_has_det, clk, rst_n, v3_reg && st3_reg == STAT_OK, d3_reg != '0)
`CCP_ASSERT_NEXT(a_accept_enters, clk, rst_n, pts_valid && !pts_stall, v1_reg)

endmodule

/* dv/tb_circumcircle_from_three_points_unit.sv */
// Self-checking testbench for the circumcircle unit: random and corner-case triangles,
// predicted in exact integer arithmetic and checked word by word. Depends on ccp_pkg and the unit.
`timescale 1ns / 1ps

class circle_scoreboard;
    ccp_pkg::circ_t pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    // Rounds n * 2^16 / d to nearest, ties away from zero.
    static function logic signed [127:0] div_round(logic signed [127:0] n,
                                                   logic signed [127:0] d);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic [127:0] r;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        nm = nm << 16;
        q = nm / dm;
        r = nm % dm;
        if (r >= dm - r)
            q = q + 1;
        return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    static function logic [47:0] clamp_center(logic signed [127:0] v);
        if (v > 128'sd140737488355327)
            return 48'h7FFF_FFFF_FFFF;
        if (v < -128'sd140737488355328)
            return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

    static function logic [47:0] radius_of(logic [127:0] ox, logic [127:0] oy);
        logic [127:0] n;
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        if (ox >= (128'd1 << 48) || oy >= (128'd1 << 48))
            return '1;
        n = ox * ox + oy * oy;
        lo = 0;
        hi = 128'd1 << 49;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        if (n > lo * lo + lo)
            lo = lo + 1;
        return (lo > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : lo[47:0];
    endfunction

    function void note_input(ccp_pkg::pts_t p);
        ccp_pkg::circ_t c;
        logic signed [127:0] ax, ay, bxd, byd, cxd, cyd, d, sb, sc, nx, ny, ox, oy;
        c = '0;
        ax = p.ax;
        ay = p.ay;
        bxd = p.bx - ax;
        byd = p.by_coord - ay;
        cxd = p.cx - ax;
        cyd = p.cy - ay;
        d = 2 * (bxd * cyd - byd * cxd);
        if (p.ax == p.bx || p.ax == p.cx)
            c.status = ccp_pkg::STAT_VERT;
        else if (p.ay == p.by_coord || p.ay == p.cy)
            c.status = ccp_pkg::STAT_HORZ;
        else if (d == 0)
            c.status = ccp_pkg::STAT_COLL;
        else
        begin
            sb = bxd * bxd + byd * byd;
            sc = cxd * cxd + cyd * cyd;
            nx = cyd * sb - byd * sc;
            ny = bxd * sc - cxd * sb;
            ox = div_round(nx, d);
            oy = div_round(ny, d);
            c.center_x = clamp_center((ax <<< 16) + ox);
            c.center_y = clamp_center((ay <<< 16) + oy);
            c.radius = radius_of((ox < 0) ? -ox : ox, (oy < 0) ? -oy : oy);
            c.status = ccp_pkg::STAT_OK;
        end
        pending.push_back(c);
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    task check_result(ccp_pkg::circ_t got);
        ccp_pkg::circ_t want;
        if (pending.size() == 0)
        begin
            report("unexpected word", got.status, 0);
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status)
            report("status", got.status, want.status);
        if (got.center_x !== want.center_x)
            report("center_x", got.center_x, want.center_x);
        if (got.center_y !== want.center_y)
            report("center_y", got.center_y, want.center_y);
        if (got.radius !== want.radius)
            report("radius", got.radius, want.radius);
    endtask
endclass

module tb_circumcircle_from_three_points_unit;
    import ccp_pkg::*;

    localparam int LATENCY = 129;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic pts_valid;
    logic pts_stall;
    pts_t pts;
    logic circ_valid;
    logic circ_stall;
    circ_t circ;

    circle_scoreboard board;
    bit calm_phase;
    bit hold_off;
    int idle_cycles;

    circumcircle_from_three_points_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .pts_valid(pts_valid),
        .pts_stall(pts_stall),
        .pts(pts),
        .circ_valid(circ_valid),
        .circ_stall(circ_stall),
        .circ(circ)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($signed($urandom_range(0, 40)) - 20);
            3: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pts_t random_triangle();
        pts_t p;
        int kind;
        p.ax = pick_coord();
        p.ay = pick_coord();
        p.bx = pick_coord();
        p.by_coord = pick_coord();
        p.cx = pick_coord();
        p.cy = pick_coord();
        kind = $urandom_range(0, 19);
        // Mostly proper triangles; a few degenerate ones of each kind.
        if (kind == 0)
            p.cx = p.ax;
        else if (kind == 1)
            p.by_coord = p.ay;
        else if (kind == 2)
        begin
            p.bx = p.ax + 16'sd3;
            p.by_coord = p.ay + 16'sd5;
            p.cx = p.ax - 16'sd6;
            p.cy = p.ay - 16'sd10;
        end
        return p;
    endfunction

    // Offers one word and holds it until accepted.
    task automatic send_word(pts_t p);
        while (!calm_phase && $urandom_range(0, 99) < 29)
        begin
            pts_valid <= 1'b0;
            @(posedge clk);
        end
        pts_valid <= 1'b1;
        pts <= p;
        @(posedge clk);
        while (pts_stall)
            @(posedge clk);
        board.note_input(p);
    endtask

    task automatic send_points(logic [15:0] ax, logic [15:0] ay, logic [15:0] bx,
                               logic [15:0] by, logic [15:0] cx, logic [15:0] cy);
        pts_t p;
        p.ax = ax;
        p.ay = ay;
        p.bx = bx;
        p.by_coord = by;
        p.cx = cx;
        p.cy = cy;
        send_word(p);
    endtask

    task automatic drain();
        pts_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && circ_valid && !circ_stall)
            board.check_result(circ);
    end

    // Receiver stall pattern, with a long hold-off on request.
    initial
    begin
        circ_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                circ_stall <= 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                circ_stall <= 1'b0;
                hold_off = 0;
            end
            else
                circ_stall <= !calm_phase && ($urandom_range(0, 99) < 29);
        end
    end

    always @(posedge clk)
    begin
        if ((pts_valid && !pts_stall) || (circ_valid && !circ_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        pts_valid = 1'b0;
        pts = '0;
        calm_phase = 0;
        hold_off = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner cases: extremes, each failure kind, priority between them.
        send_points(16'sd0, 16'sd0, 16'sd4, 16'sd2, 16'sd2, 16'sd6);
        send_points(16'h8000, 16'h8000, 16'h7FFF, 16'h8001, 16'h8001, 16'h7FFF);
        send_points(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFE, 16'h7FFE, 16'h8000);
        send_points(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h8001);
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd3);
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd2, 16'sd1);
        send_points(16'sd5, 16'sd1, 16'sd5, 16'sd7, 16'sd9, 16'sd3);
        send_points(16'sd5, 16'sd1, 16'sd8, 16'sd7, 16'sd5, 16'sd3);
        send_points(16'sd5, 16'sd1, 16'sd5, 16'sd1, 16'sd9, 16'sd1);
        send_points(16'sd5, 16'sd1, 16'sd8, 16'sd1, 16'sd9, 16'sd3);
        send_points(16'sd5, 16'sd1, 16'sd8, 16'sd3, 16'sd9, 16'sd1);
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3, 16'sd6);
        send_points(16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd2, 16'sd2);
        send_points(16'sd0, 16'sd0, 16'sd1, 16'sd3, 16'sd3, 16'sd1);
        send_points(16'sd1, 16'sd2, 16'sd2, 16'sd5, 16'sd7, 16'sd3);
        send_points(16'h8000, 16'h8000, 16'h8001, 16'h7FFF, 16'h7FFF, 16'h7FFE);
        send_points(16'hFFFF, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001, 16'hAAAB);
        send_points(16'sd0, 16'sd0, 16'sd2, 16'sd1, 16'sd4, 16'sd3);
        drain();

        // Fill the pipeline while the receiver holds off.
        hold_off = 1;
        repeat (300) send_word(random_triangle());
        drain();

        calm_phase = 1;
        repeat (150) send_word(random_triangle());
        calm_phase = 0;
        repeat (400) send_word(random_triangle());
        drain();

        repeat (LATENCY + 20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
